// File: design/bfiq_pkg.sv
// Shared constants and types for the Bloom filter insert/query engine.
// No dependencies; used by bloom_filter_insert_query_top.
package bfiq_pkg;

	// Filter store geometry
	localparam int unsigned MAX_WORDS     = 4096;
	localparam int unsigned WORD_W        = 32;
	localparam int unsigned BIT_W         = $clog2(WORD_W);
	localparam int unsigned ADDR_W        = $clog2(MAX_WORDS);
	localparam int unsigned MOD_LIMIT     = MAX_WORDS * WORD_W;
	localparam int unsigned REM_W         = $clog2(MOD_LIMIT);
	localparam int unsigned MOD_W         = REM_W + 1;

	// Hash functions
	localparam int unsigned MAX_FUNCTIONS = 16;
	localparam int unsigned FN_W          = $clog2(MAX_FUNCTIONS + 1);
	localparam int unsigned FIDX_W        = 4;
	localparam int unsigned KEY_W         = 32;
	localparam int unsigned STEP_W        = $clog2(KEY_W);

	// Configuration port
	localparam int unsigned CFG_IDX_W     = 3;
	localparam int unsigned CFG_DATA_W    = 64;
	localparam int unsigned FBITS_W       = 18;
	localparam int unsigned NFUNC_W       = 5;

	localparam logic [CFG_IDX_W-1:0] REG_FILTER_BITS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_FUNCTIONS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FACTORS_LOW   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FACTORS_HIGH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_TABLE   = 3'd4;

	localparam logic [FBITS_W-1:0] FILTER_BITS_RST   = 18'd131072;
	localparam logic [NFUNC_W-1:0] NUM_FUNCTIONS_RST = 5'd13;

	// Item kinds
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

	// Sequencer states, one-hot
	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_MUL1  = 8'b0000_0100,
		ST_MUL2  = 8'b0000_1000,
		ST_MOD   = 8'b0001_0000,
		ST_RD    = 8'b0010_0000,
		ST_CHK   = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

endpackage

// File: design/bloom_filter_insert_query_top.sv
// Bloom filter insert/query engine: sequencer, shared multiplier and remainder unit,
// filter store. Depends on bfiq_pkg.
//
// Each input word inserts a 32-bit key into, or queries it against, a Bloom filter of
// 4096 x 32-bit words. After reset the store is swept to zero, one word a cycle;
// s_tready stays low meanwhile, configuration writes are taken as ever.
// Per hash function the engine runs two multiplier steps (f*f, then
// key*f*f with the left shift), 32 steps of a bit-serial remainder unit against the
// filter size, one store read and one check or read-modify-write. This repeats for n
// functions, n being the function count (saturated to 16), before the next key can
// be taken. Exactly one result word leaves per key; it sits in an output register so
// the next key may be taken while it waits. Configuration must only change while the
// engine is idle.
module bloom_filter_insert_query_top (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_we,
	input  logic [bfiq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bfiq_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	// input stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [bfiq_pkg::KEY_W-1:0]         s_tdata,   // [31:0] key
	input  logic                               s_tuser,   // [0] kind
	// result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [bfiq_pkg::KEY_W-1:0]         m_tdata,   // [31:0] key_out
	output logic                               m_tuser    // [0] member
);

	// Configuration registers
	logic [bfiq_pkg::FBITS_W-1:0]    filter_bits_q;
	logic [bfiq_pkg::NFUNC_W-1:0]    num_functions_q;
	logic [bfiq_pkg::CFG_DATA_W-1:0] factors_low_q;
	logic [bfiq_pkg::CFG_DATA_W-1:0] factors_high_q;
	logic [bfiq_pkg::CFG_DATA_W-1:0] shift_table_q;

	// Sequencer and datapath
	bfiq_pkg::state_t                state_q;
	logic [bfiq_pkg::ADDR_W-1:0]     clr_q;
	logic                            kind_q;
	logic [bfiq_pkg::KEY_W-1:0]      key_q;
	logic [bfiq_pkg::FN_W-1:0]       fn_q;
	logic [bfiq_pkg::FN_W-1:0]       cnt_q;
	logic [bfiq_pkg::MOD_W-1:0]      mod_q;
	logic [15:0]                     ff_q;
	logic [bfiq_pkg::KEY_W-1:0]      dvd_q;
	logic [bfiq_pkg::REM_W-1:0]      rem_q;
	logic [bfiq_pkg::STEP_W-1:0]     step_q;
	logic                            miss_q;
	logic [bfiq_pkg::WORD_W-1:0]     rd_data_q;
	logic [bfiq_pkg::WORD_W-1:0]     filter_q [bfiq_pkg::MAX_WORDS];

	// Output register
	logic                            out_valid_q;
	logic [bfiq_pkg::KEY_W-1:0]      out_key_q;
	logic                            out_member_q;

	logic                            accept;
	logic [bfiq_pkg::FIDX_W-1:0]     fidx;
	logic [7:0]                      factor;
	logic [3:0]                      shamt;
	logic [47:0]                     prod;
	logic [bfiq_pkg::MOD_W-1:0]      part;
	logic [bfiq_pkg::MOD_W-1:0]      mod_eff;
	logic [bfiq_pkg::FN_W-1:0]       cnt_eff;
	logic [bfiq_pkg::ADDR_W-1:0]     word_addr;
	logic [bfiq_pkg::WORD_W-1:0]     bit_mask;
	logic                            mem_we;
	logic [bfiq_pkg::ADDR_W-1:0]     mem_waddr;
	logic [bfiq_pkg::WORD_W-1:0]     mem_wdata;
	logic                            load_out;

	assign s_tready = (state_q == bfiq_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_key_q;
	assign m_tuser  = out_member_q;

	// Effective modulus and function count
	always_comb begin
		if (filter_bits_q == '0 || 32'(filter_bits_q) > bfiq_pkg::MOD_LIMIT) begin
			mod_eff = bfiq_pkg::MOD_W'(bfiq_pkg::MOD_LIMIT);
		end else begin
			mod_eff = bfiq_pkg::MOD_W'(filter_bits_q);
		end
		if (32'(num_functions_q) > bfiq_pkg::MAX_FUNCTIONS) begin
			cnt_eff = bfiq_pkg::FN_W'(bfiq_pkg::MAX_FUNCTIONS);
		end else begin
			cnt_eff = bfiq_pkg::FN_W'(num_functions_q);
		end
	end

	// Per-function factor and shift
	assign fidx   = fn_q[bfiq_pkg::FIDX_W-1:0];
	assign factor = fidx[3] ? factors_high_q[{fidx[2:0], 3'b000} +: 8]
	                        : factors_low_q[{fidx[2:0], 3'b000} +: 8];
	assign shamt  = shift_table_q[{fidx, 2'b00} +: 4];
	assign prod   = 48'(key_q) * 48'(ff_q);

	// Remainder step and bit position
	assign part      = {rem_q, dvd_q[bfiq_pkg::KEY_W-1]};
	assign word_addr = rem_q[bfiq_pkg::REM_W-1:bfiq_pkg::BIT_W];
	assign bit_mask  = bfiq_pkg::WORD_W'(1) << rem_q[bfiq_pkg::BIT_W-1:0];

	// Store write port: clearing sweep or insert update
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = word_addr;
		mem_wdata = rd_data_q | bit_mask;
		if (state_q == bfiq_pkg::ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (state_q == bfiq_pkg::ST_CHK && kind_q == bfiq_pkg::KIND_INSERT) begin
			mem_we = 1'b1;
		end
	end

	assign load_out = (state_q == bfiq_pkg::ST_DONE) && (!out_valid_q || m_tready);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_bits_q   <= bfiq_pkg::FILTER_BITS_RST;
			num_functions_q <= bfiq_pkg::NUM_FUNCTIONS_RST;
			factors_low_q   <= '0;
			factors_high_q  <= '0;
			shift_table_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				bfiq_pkg::REG_FILTER_BITS:   filter_bits_q   <= cfg_wdata[bfiq_pkg::FBITS_W-1:0];
				bfiq_pkg::REG_NUM_FUNCTIONS: num_functions_q <= cfg_wdata[bfiq_pkg::NFUNC_W-1:0];
				bfiq_pkg::REG_FACTORS_LOW:   factors_low_q   <= cfg_wdata;
				bfiq_pkg::REG_FACTORS_HIGH:  factors_high_q  <= cfg_wdata;
				bfiq_pkg::REG_SHIFT_TABLE:   shift_table_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Filter store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			filter_q[mem_waddr] <= mem_wdata;
		end
		if (state_q == bfiq_pkg::ST_RD) begin
			rd_data_q <= filter_q[word_addr];
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfiq_pkg::ST_CLEAR;
			clr_q   <= '0;
			fn_q    <= '0;
			step_q  <= '0;
		end else begin
			case (state_q)
				bfiq_pkg::ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == bfiq_pkg::ADDR_W'(bfiq_pkg::MAX_WORDS - 1)) begin
						state_q <= bfiq_pkg::ST_IDLE;
					end
				end
				bfiq_pkg::ST_IDLE: begin
					fn_q <= '0;
					if (accept) begin
						state_q <= (cnt_eff == '0) ? bfiq_pkg::ST_DONE : bfiq_pkg::ST_MUL1;
					end
				end
				bfiq_pkg::ST_MUL1: state_q <= bfiq_pkg::ST_MUL2;
				bfiq_pkg::ST_MUL2: begin
					step_q  <= '0;
					state_q <= bfiq_pkg::ST_MOD;
				end
				bfiq_pkg::ST_MOD: begin
					step_q <= step_q + 1'b1;
					if (step_q == bfiq_pkg::STEP_W'(bfiq_pkg::KEY_W - 1)) begin
						state_q <= bfiq_pkg::ST_RD;
					end
				end
				bfiq_pkg::ST_RD: state_q <= bfiq_pkg::ST_CHK;
				bfiq_pkg::ST_CHK: begin
					fn_q <= fn_q + 1'b1;
					if (fn_q + 1'b1 == cnt_q) begin
						state_q <= bfiq_pkg::ST_DONE;
					end else begin
						state_q <= bfiq_pkg::ST_MUL1;
					end
				end
				bfiq_pkg::ST_DONE: begin
					if (load_out) begin
						state_q <= bfiq_pkg::ST_IDLE;
					end
				end
				default: state_q <= bfiq_pkg::ST_IDLE;
			endcase
		end
	end

	// Datapath: key capture, shared multiplier, bit-serial remainder, bit test
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q  <= s_tdata;
			kind_q <= s_tuser;
			cnt_q  <= cnt_eff;
			mod_q  <= mod_eff;
			miss_q <= 1'b0;
		end
		if (state_q == bfiq_pkg::ST_MUL1) begin
			ff_q <= 16'(factor) * 16'(factor);
		end
		if (state_q == bfiq_pkg::ST_MUL2) begin
			dvd_q <= prod[bfiq_pkg::KEY_W-1:0] << shamt;
			rem_q <= '0;
		end
		if (state_q == bfiq_pkg::ST_MOD) begin
			dvd_q <= {dvd_q[bfiq_pkg::KEY_W-2:0], 1'b0};
			if (part >= mod_q) begin
				rem_q <= bfiq_pkg::REM_W'(part - mod_q);
			end else begin
				rem_q <= part[bfiq_pkg::REM_W-1:0];
			end
		end
		if (state_q == bfiq_pkg::ST_CHK && (rd_data_q & bit_mask) == '0) begin
			miss_q <= 1'b1;
		end
	end

	// Output register; hold the word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_key_q    <= key_q;
			out_member_q <= (kind_q == bfiq_pkg::KIND_QUERY) && !miss_q;
		end
	end

`ifndef SYNTHESIS
	// An accepted key keeps the engine busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("engine ready right after accepting a key");

	// Remainder stays below the modulus throughout the division
	a_rem_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bfiq_pkg::ST_MOD) |-> (bfiq_pkg::MOD_W'(rem_q) < mod_q))
		else $error("remainder reached the modulus");

	// The store is written only by the sweep or an insert update
	a_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == bfiq_pkg::ST_CLEAR ||
			(state_q == bfiq_pkg::ST_CHK && kind_q == bfiq_pkg::KIND_INSERT)))
		else $error("unexpected filter store write");

	// A result is loaded only when the output register is free or being emptied
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bfiq_pkg::ST_DONE && out_valid_q && !m_tready) |=> out_valid_q)
		else $error("pending result word lost");
`endif

endmodule
